@@ rtl/core/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet during reset
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, quiet during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ rtl/core/tll_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package tll_pkg;

	localparam int POS_WIDTH_DEF   = 16;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int KIND_W          = 4;
	localparam int OUT_POS_W       = 16;
	localparam int SLOTS           = 3;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_INT,
		MODE_WORD
	} mode_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_INT   = 4'd0,
		KIND_IDENT = 4'd1,
		KIND_LET   = 4'd2,
		KIND_EXIT  = 4'd3,
		KIND_PLUS  = 4'd4,
		KIND_MINUS = 4'd5,
		KIND_STAR  = 4'd6,
		KIND_SLASH = 4'd7,
		KIND_EQ    = 4'd8,
		KIND_SEMI  = 4'd9,
		KIND_END   = 4'd10
	} kind_t;

	typedef struct packed {
		logic  hit;
		kind_t kind;
	} op_t;

	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_EQ    = 8'h3d;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// first bytes of a word, first byte in the low lane
	localparam logic [31:0] WORD_LET  = 32'h0074656c;
	localparam logic [31:0] WORD_EXIT = 32'h74697865;

	function automatic logic is_digit(logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

	function automatic logic is_alpha(logic [7:0] b);
		return ((b >= 8'h61) && (b <= 8'h7a)) || ((b >= 8'h41) && (b <= 8'h5a));
	endfunction

	function automatic op_t op_decode(logic [7:0] b);
		op_t r;
		r.hit  = 1'b1;
		r.kind = KIND_PLUS;
		unique case (b)
			CH_PLUS:  r.kind = KIND_PLUS;
			CH_MINUS: r.kind = KIND_MINUS;
			CH_STAR:  r.kind = KIND_STAR;
			CH_SLASH: r.kind = KIND_SLASH;
			CH_EQ:    r.kind = KIND_EQ;
			CH_SEMI:  r.kind = KIND_SEMI;
			default:  r.hit  = 1'b0;
		endcase
		return r;
	endfunction

	function automatic kind_t word_kind(mode_t m, logic is3, logic is4, logic [31:0] fc);
		kind_t k;
		if (m == MODE_INT)
			k = KIND_INT;
		else if (is3 && fc == WORD_LET)
			k = KIND_LET;
		else if (is4 && fc == WORD_EXIT)
			k = KIND_EXIT;
		else
			k = KIND_IDENT;
		return k;
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/tll_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tll_front import tll_pkg::*; #(
	parameter int POS_WIDTH = POS_WIDTH_DEF,
	localparam int TOK_W = KIND_W + 2 * POS_WIDTH,
	localparam int REC_W = SLOTS * TOK_W + SLOTS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       ch,
	input  logic             has_byte,
	input  logic             end_of_input,
	input  logic             q_full,
	output logic             q_push,
	output logic [REC_W-1:0] q_rec
);

	localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

	mode_t                mode_q, mode_d;
	logic [POS_WIDTH-1:0] tstart_q, tstart_d;
	logic [POS_WIDTH-1:0] tlen_q, tlen_d;
	logic [31:0]          fc_q, fc_d;
	logic [POS_WIDTH-1:0] pos_q, pos_d;

	logic                 accept;
	logic                 dig, alp, ext, brk;
	op_t                  op;
	mode_t                mode1;
	logic [POS_WIDTH-1:0] start1, len1, pos1;
	logic [31:0]          fc1;
	logic [TOK_W-1:0]     tok0, tok1, tok2;
	logic [SLOTS-1:0]     mask;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	always_comb begin
		dig = is_digit(ch);
		alp = is_alpha(ch);
		op  = op_decode(ch);
		ext = has_byte && ((mode_q == MODE_INT && dig) ||
			(mode_q == MODE_WORD && (alp || dig)));
		brk = has_byte && !ext;

		// state once the byte is taken in
		mode1  = mode_q;
		start1 = tstart_q;
		len1   = tlen_q;
		fc1    = fc_q;
		if (ext) begin
			if (tlen_q < POS_WIDTH'(4))
				fc1 = fc_q | ({24'b0, ch} << {tlen_q[1:0], 3'b000});
			len1 = (tlen_q == POS_MAX) ? tlen_q : tlen_q + 1'b1;
		end else if (brk) begin
			start1 = pos_q;
			len1   = POS_WIDTH'(1);
			fc1    = {24'b0, ch};
			if (dig)
				mode1 = MODE_INT;
			else if (alp)
				mode1 = MODE_WORD;
			else
				mode1 = MODE_IDLE;
		end
		pos1 = (has_byte && pos_q != POS_MAX) ? pos_q + 1'b1 : pos_q;

		// slot 0: pending token closed by this byte
		mask[0] = brk && mode_q != MODE_IDLE;
		tok0 = {word_kind(mode_q, tlen_q == POS_WIDTH'(3), tlen_q == POS_WIDTH'(4), fc_q),
			tstart_q, tlen_q};

		// slot 1: operator, or the token still open at end of input
		if (brk && op.hit) begin
			mask[1] = 1'b1;
			tok1    = {op.kind, pos_q, POS_WIDTH'(1)};
		end else begin
			mask[1] = end_of_input && mode1 != MODE_IDLE;
			tok1    = {word_kind(mode1, len1 == POS_WIDTH'(3), len1 == POS_WIDTH'(4), fc1),
				start1, len1};
		end

		mask[2] = end_of_input;
		tok2    = {KIND_END, pos1, POS_WIDTH'(0)};

		if (end_of_input) begin
			mode_d   = MODE_IDLE;
			tstart_d = '0;
			tlen_d   = '0;
			fc_d     = '0;
			pos_d    = '0;
		end else begin
			mode_d   = mode1;
			tstart_d = start1;
			tlen_d   = len1;
			fc_d     = fc1;
			pos_d    = pos1;
		end
	end

	assign q_push = accept && (mask != '0);
	assign q_rec  = {tok2, tok1, tok0, mask};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			tstart_q <= '0;
			tlen_q   <= '0;
			fc_q     <= '0;
			pos_q    <= '0;
		end else if (accept) begin
			mode_q   <= mode_d;
			tstart_q <= tstart_d;
			tlen_q   <= tlen_d;
			fc_q     <= fc_d;
			pos_q    <= pos_d;
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/tll_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tll_queue import tll_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH_DEF,
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rdata     = entry_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (pop)
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/tll_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tll_back import tll_pkg::*; #(
	parameter int POS_WIDTH = POS_WIDTH_DEF,
	localparam int TOK_W = KIND_W + 2 * POS_WIDTH,
	localparam int REC_W = SLOTS * TOK_W + SLOTS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_not_empty,
	input  logic [REC_W-1:0]     q_rec,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [KIND_W-1:0]    kind,
	output logic [OUT_POS_W-1:0] start_pos,
	output logic [OUT_POS_W-1:0] length,
	output logic                 run_last
);

	logic [SLOTS-1:0]     done_q;
	logic [SLOTS-1:0]     remain, pick;
	logic [TOK_W-1:0]     tok;
	logic                 is_last, load;
	logic                 out_valid_q;
	logic [KIND_W-1:0]    kind_q;
	logic [OUT_POS_W-1:0] start_q, len_q;
	logic                 last_q;

	always_comb begin
		remain = q_rec[SLOTS-1:0] & ~done_q;
		if (remain[0]) begin
			pick = 3'b001;
			tok  = q_rec[SLOTS +: TOK_W];
		end else if (remain[1]) begin
			pick = 3'b010;
			tok  = q_rec[SLOTS + TOK_W +: TOK_W];
		end else begin
			pick = 3'b100;
			tok  = q_rec[SLOTS + 2 * TOK_W +: TOK_W];
		end
		is_last = (remain & ~pick) == '0;
	end

	// output register takes a token when empty or draining
	assign load  = q_not_empty && (!out_valid_q || !out_stall);
	assign q_pop = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				done_q <= is_last ? '0 : (done_q | pick);
			if (load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q  <= tok[TOK_W-1 -: KIND_W];
			start_q <= OUT_POS_W'(tok[POS_WIDTH +: POS_WIDTH]);
			len_q   <= OUT_POS_W'(tok[POS_WIDTH-1:0]);
			last_q  <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign start_pos = start_q;
	assign length    = len_q;
	assign run_last  = last_q;

endmodule
`default_nettype wire

@@ rtl/core/toy_language_lexer.sv @@
// byte-stream lexer: one source byte in, zero to three tokens out
// input channel: in_valid/in_stall with ch, has_byte, end_of_input;
//   has_byte low with end_of_input high is a bare end marker
// output channel: out_valid/out_stall with kind, start_pos, length, run_last;
//   run_last marks the final token caused by one input byte
// the front scanner takes one byte per cycle unless the queue is full and writes
//   the tokens it causes as one record into a small queue; the back end sends one
//   token per cycle unless out_stall holds it, through a registered output stage
// throughput: one byte per cycle while each byte causes at most one token and
//   out_stall stays low; a byte causing k tokens sends them one after another
//   through the single output register
// in_stall rises only when the queue is full, e.g. while out_stall is held
// out_stall freezes the output token; the front keeps scanning until the
//   queue fills
// reset clears the scan state, the position counter, the queue and the
//   output valid flag; after an end token the stream restarts at offset 0
`timescale 1ns / 1ps
`default_nettype none
module toy_language_lexer import tll_pkg::*; #(
	parameter int POS_WIDTH   = POS_WIDTH_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           ch,
	input  logic                 has_byte,
	input  logic                 end_of_input,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [KIND_W-1:0]    kind,
	output logic [OUT_POS_W-1:0] start_pos,
	output logic [OUT_POS_W-1:0] length,
	output logic                 run_last
);

	localparam int TOK_W = KIND_W + 2 * POS_WIDTH;
	localparam int REC_W = SLOTS * TOK_W + SLOTS;

	logic             q_push, q_full, q_pop, q_not_empty;
	logic [REC_W-1:0] push_rec, head_rec;

	tll_front #(.POS_WIDTH(POS_WIDTH)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.ch           (ch),
		.has_byte     (has_byte),
		.end_of_input (end_of_input),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_rec        (push_rec)
	);

	tll_queue #(.WIDTH(REC_W), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wdata     (push_rec),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.rdata     (head_rec)
	);

	tll_back #(.POS_WIDTH(POS_WIDTH)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_rec       (head_rec),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.start_pos   (start_pos),
		.length      (length),
		.run_last    (run_last)
	);

endmodule
`default_nettype wire

@@ rtl/core/tll_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tll_checker import tll_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [KIND_W-1:0]    kind,
	input logic [OUT_POS_W-1:0] start_pos,
	input logic [OUT_POS_W-1:0] length,
	input logic                 run_last
);

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(kind) && $stable(start_pos) && $stable(length) && $stable(run_last))
	`ASSERT_IMPLY(a_end_tok, clk, arst_n, out_valid && kind == KIND_END, length == '0 && run_last)
	`ASSERT_IMPLY(a_op_len, clk, arst_n, out_valid && kind >= KIND_PLUS && kind <= KIND_SEMI, length == OUT_POS_W'(1))
	`ASSERT_IMPLY(a_mid_run, clk, arst_n, out_valid && !run_last, kind != KIND_END)

endmodule

bind toy_language_lexer tll_checker u_chk (.*);
`default_nettype wire

@@ tb/tb_toy_language_lexer.sv @@
`timescale 1ns / 1ps
module tb_toy_language_lexer;
	import tll_pkg::*;

	// first byte of a word sits in the low lane
	localparam logic [31:0] LET_BYTES  = {8'h00, "t", "e", "l"};
	localparam logic [31:0] EXIT_BYTES = {"t", "i", "x", "e"};
	localparam logic [15:0] POS_SAT    = 16'hffff;
	localparam int RANDOM_ITEMS        = 80;

	typedef struct {
		kind_t       kind;
		logic [15:0] start;
		logic [15:0] len;
		logic        last;
	} token_t;

	class token_scoreboard;
		token_t      pending_tokens[$];
		int unsigned errors = 0;
		mode_t       scan = MODE_IDLE;
		logic [15:0] tok_start = '0;
		logic [15:0] tok_len = '0;
		logic [31:0] head_bytes = '0;
		logic [15:0] offset = '0;

		function bit is_num(logic [7:0] b);
			return b >= "0" && b <= "9";
		endfunction

		function bit is_letter(logic [7:0] b);
			return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
		endfunction

		function logic [15:0] bump(logic [15:0] v);
			return (v == POS_SAT) ? v : v + 16'd1;
		endfunction

		function bit op_of(logic [7:0] b, output kind_t k);
			k = KIND_PLUS;
			case (b)
				"+": k = KIND_PLUS;
				"-": k = KIND_MINUS;
				"*": k = KIND_STAR;
				"/": k = KIND_SLASH;
				"=": k = KIND_EQ;
				";": k = KIND_SEMI;
				default: return 1'b0;
			endcase
			return 1'b1;
		endfunction

		function void add_token(kind_t k, logic [15:0] s, logic [15:0] l);
			token_t t;
			t.kind = k;
			t.start = s;
			t.len = l;
			t.last = 1'b0;
			pending_tokens = {pending_tokens, t};
		endfunction

		function void close_token();
			kind_t k;
			if (scan == MODE_IDLE)
				return;
			if (scan == MODE_INT)
				k = KIND_INT;
			else if (tok_len == 16'd3 && head_bytes == LET_BYTES)
				k = KIND_LET;
			else if (tok_len == 16'd4 && head_bytes == EXIT_BYTES)
				k = KIND_EXIT;
			else
				k = KIND_IDENT;
			add_token(k, tok_start, tok_len);
			scan = MODE_IDLE;
		endfunction

		function void open_token(mode_t m, logic [7:0] b);
			scan = m;
			tok_start = offset;
			tok_len = 16'd1;
			head_bytes = {24'h0, b};
		endfunction

		// lex one accepted transfer into the tokens it must produce
		function void note_byte(logic [7:0] b, logic hb, logic eoi);
			int    n_prior;
			bit    grow;
			kind_t k;
			n_prior = pending_tokens.size();
			if (hb) begin
				grow = (scan == MODE_INT && is_num(b)) ||
					(scan == MODE_WORD && (is_num(b) || is_letter(b)));
				if (grow) begin
					if (tok_len < 16'd4)
						head_bytes |= {24'h0, b} << (8 * tok_len);
					tok_len = bump(tok_len);
				end else begin
					close_token();
					if (is_num(b))
						open_token(MODE_INT, b);
					else if (is_letter(b))
						open_token(MODE_WORD, b);
					else if (op_of(b, k))
						add_token(k, offset, 16'd1);
				end
				offset = bump(offset);
			end
			if (eoi) begin
				close_token();
				add_token(KIND_END, offset, 16'd0);
				scan = MODE_IDLE;
				tok_start = '0;
				tok_len = '0;
				head_bytes = '0;
				offset = '0;
			end
			if (pending_tokens.size() > n_prior)
				pending_tokens[pending_tokens.size() - 1].last = 1'b1;
		endfunction

		function void check_token(logic [3:0] k, logic [15:0] s, logic [15:0] l, logic rl);
			token_t t;
			if (pending_tokens.size() == 0) begin
				$error("token with none expected: kind %0d start %0d length %0d", k, s, l);
				errors++;
				return;
			end
			t = pending_tokens.pop_front();
			if (k !== t.kind) begin
				$error("kind: expected %0d, got %0d", t.kind, k);
				errors++;
			end
			if (s !== t.start) begin
				$error("start_pos: expected %0d, got %0d", t.start, s);
				errors++;
			end
			if (l !== t.len) begin
				$error("length: expected %0d, got %0d", t.len, l);
				errors++;
			end
			if (rl !== t.last) begin
				$error("run_last: expected %0d, got %0d", t.last, rl);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  ch;
	logic        has_byte;
	logic        end_of_input;
	logic        out_valid;
	logic        out_stall;
	logic [3:0]  kind;
	logic [15:0] start_pos;
	logic [15:0] length;
	logic        run_last;

	token_scoreboard sb;
	int unsigned     send_idle_pct;
	int unsigned     recv_stall_pct;
	int unsigned     items_sent;
	logic [7:0]      src_bytes[$];
	string           keyword_like[10] = '{"le", "lets", "exi", "exits", "Let",
		"EXIT", "lex", "exil", "letter", "exit9"};
	int unsigned     idle_by_phase[4] = '{0, 73, 0, 35};
	int unsigned     stall_by_phase[4] = '{0, 0, 73, 35};

	toy_language_lexer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.ch           (ch),
		.has_byte     (has_byte),
		.end_of_input (end_of_input),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.start_pos    (start_pos),
		.length       (length),
		.run_last     (run_last)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0)
			sb.check_token(kind, start_pos, length, run_last);
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task automatic send_item(input logic [7:0] b, input logic hb, input logic eoi);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			ch <= 8'($urandom_range(255));
			has_byte <= 1'($urandom_range(1));
			end_of_input <= 1'($urandom_range(1));
			@(posedge clk);
		end
		in_valid <= 1'b1;
		ch <= b;
		has_byte <= hb;
		end_of_input <= eoi;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_byte(b, hb, eoi);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b1, 1'b0);
	endtask

	function automatic logic [7:0] rand_letter();
		if ($urandom_range(1))
			return 8'($urandom_range(25)) + "a";
		return 8'($urandom_range(25)) + "A";
	endfunction

	function automatic logic [7:0] rand_alnum();
		if ($urandom_range(2) == 0)
			return 8'($urandom_range(9)) + "0";
		return rand_letter();
	endfunction

	function automatic logic [7:0] rand_space();
		case ($urandom_range(5))
			0: return 8'h20;
			1: return 8'h09;
			2: return 8'h0a;
			3: return 8'h0b;
			4: return 8'h0c;
			default: return 8'h0d;
		endcase
	endfunction

	function automatic void add_src(logic [7:0] b);
		src_bytes = {src_bytes, b};
	endfunction

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++)
			add_src(s[i]);
	endfunction

	function automatic void push_word();
		int pick;
		pick = $urandom_range(99);
		if (pick < 15)
			push_text("let");
		else if (pick < 30)
			push_text("exit");
		else if (pick < 45)
			push_text(keyword_like[$urandom_range(9)]);
		else begin
			add_src(rand_letter());
			repeat ($urandom_range(7))
				add_src(rand_alnum());
		end
	endfunction

	function automatic void push_op();
		string ops;
		ops = "+-*/=;";
		add_src(ops[$urandom_range(5)]);
	endfunction

	// a source line of words, numbers and operators with some junk mixed in
	function automatic void build_stream();
		int n_tok;
		int pick;
		src_bytes.delete();
		n_tok = $urandom_range(1, 10);
		for (int t = 0; t < n_tok; t++) begin
			pick = $urandom_range(99);
			if (pick < 30)
				push_word();
			else if (pick < 50)
				repeat ($urandom_range(1, 6))
					add_src(8'($urandom_range(9)) + "0");
			else if (pick < 85)
				push_op();
			else
				add_src(8'($urandom_range(255)));
			pick = $urandom_range(99);
			if (pick < 60)
				repeat ($urandom_range(1, 3))
					add_src(rand_space());
			else if (pick < 70)
				add_src(8'($urandom_range(128, 255)));
		end
	endfunction

	task automatic send_stream(input bit eoi_on_byte);
		bit last;
		foreach (src_bytes[i]) begin
			last = eoi_on_byte && (i == src_bytes.size() - 1);
			send_item(src_bytes[i], 1'b1, last);
			items_sent++;
			if ($urandom_range(99) < 3)
				send_item(8'($urandom_range(255)), 1'b0, 1'b0);
		end
		if (!eoi_on_byte) begin
			send_item(8'($urandom_range(255)), 1'b0, 1'b1);
			items_sent++;
		end
	endtask

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		sb = new;
		arst_n = 1'b0;
		in_valid = 1'b0;
		ch = 8'h00;
		has_byte = 1'b0;
		end_of_input = 1'b0;
		out_stall = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		items_sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed lines: keywords, all operators, every blank, high bytes
		send_text("let ab9=07;");
		send_item(8'h41, 1'b0, 1'b1);
		send_item(8'h00, 1'b0, 1'b1);
		send_text("exit");
		send_item(8'hff, 1'b1, 1'b0);
		send_text("+-*/");
		send_item(8'h09, 1'b1, 1'b0);
		send_item(8'h0a, 1'b1, 1'b0);
		send_item(8'h0b, 1'b1, 1'b0);
		send_item(8'h0c, 1'b1, 1'b0);
		send_item(8'h0d, 1'b1, 1'b0);
		send_text("Zz");
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'h5a, 1'b0, 1'b0);
		send_item("9", 1'b1, 1'b1);
		// pending word, operator and end token from a single transfer
		send_text("q");
		send_item("+", 1'b1, 1'b1);

		// a long word runs well past the keyword window
		src_bytes.delete();
		add_src("w");
		repeat (24)
			add_src(rand_alnum());
		push_text(" 12=");
		send_stream(1'b0);

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = idle_by_phase[ph];
			recv_stall_pct = stall_by_phase[ph];
			items_sent = 0;
			while (items_sent < RANDOM_ITEMS) begin
				build_stream();
				send_stream($urandom_range(1));
			end
		end

		in_valid <= 1'b0;
		while (sb.pending_tokens.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/tll_pkg.sv
rtl/core/tll_front.sv
rtl/core/tll_queue.sv
rtl/core/tll_back.sv
rtl/core/toy_language_lexer.sv
rtl/core/tll_checker.sv
tb/tb_toy_language_lexer.sv
